// File: hw/rtl/itaf_pkg.sv
// Package for the integer to ASCII formatter: codes, constants, stage type and helpers.
`default_nettype none

package itaf_pkg;

    // Operand and digit geometry.
    localparam int VAL_W        = 32;
    localparam int DEC_DIGITS   = 10;
    localparam int BCD_W        = 4 * DEC_DIGITS;
    localparam int MAX_DIGITS   = 11;
    localparam int BITS_PER_STG = 4;
    localparam int DAB_STAGES   = VAL_W / BITS_PER_STG;
    localparam int NSTAGE       = DAB_STAGES + 1;

    // Format selector codes.
    localparam logic [2:0] REQ_CHAR = 3'd0;
    localparam logic [2:0] REQ_SDEC = 3'd1;
    localparam logic [2:0] REQ_UDEC = 3'd2;
    localparam logic [2:0] REQ_OCT  = 3'd3;
    localparam logic [2:0] REQ_HEX  = 3'd4;

    // ASCII characters used around the digits.
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // One pipeline stage of the conversion.
    typedef struct packed {
        logic [2:0]       kind;
        logic             neg;
        logic [VAL_W-1:0] mag;
        logic [VAL_W-1:0] sh;
        logic [BCD_W-1:0] bcd;
    } itaf_stage_t;

    // Digit value to uppercase ASCII.
    function automatic logic [7:0] hex_char(input logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10) begin
            c = CH_ZERO + {4'd0, d};
        end else begin
            c = 8'h41 + {4'd0, d - 4'd10};
        end
        return c;
    endfunction

    // Four shift-and-add-3 steps of binary to BCD conversion.
    function automatic itaf_stage_t dabble4(input itaf_stage_t s);
        itaf_stage_t r;
        logic [BCD_W-1:0] b;
        logic [VAL_W-1:0] h;
        r = s;
        b = s.bcd;
        h = s.sh;
        for (int step = 0; step < BITS_PER_STG; step++) begin
            for (int d = 0; d < DEC_DIGITS; d++) begin
                if (b[4*d +: 4] >= 4'd5) begin
                    b[4*d +: 4] = b[4*d +: 4] + 4'd3;
                end
            end
            b = {b[BCD_W-2:0], h[VAL_W-1]};
            h = {h[VAL_W-2:0], 1'b0};
        end
        r.bcd = b;
        r.sh  = h;
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/integer_to_ascii_formatter_top.sv
// Top level of the integer to ASCII formatter: conversion pipeline and character emitter.
//
// Usage:
// A request enters on the s_ channel with the operand in s_tdata and the format
// selector in s_tuser (0 character, 1 signed decimal, 2 unsigned decimal,
// 3 octal, 4 hex). Selector codes 5 to 7 are taken and dropped without output.
// Each request yields a run of ASCII characters on the m_ channel, one per
// request there, with m_tlast on the final character of the run.
// Path: a request passes the input register and eight binary-to-BCD stages of
// four bits each, then the emitter load, before its first character is offered,
// when the emitter is free.
// Throughput: the emitter sends one character per cycle while m_tready is high.
// A run is 1 character long for character mode, up to 12 for decimal, 13 for
// octal and 11 for hex. The pipeline takes a request in every cycle until its
// stages fill behind a busy emitter.
// Stall: while m_tready is low the current character holds and the pipeline
// stages fill in turn; s_tready drops only when all of them hold a request.
// Reset: aresetn low at a clock edge empties every stage and the emitter.
`default_nettype none

module integer_to_ascii_formatter_top
    import itaf_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [VAL_W-1:0] s_tdata,   // [31:0] value
    input  wire logic [2:0]       s_tuser,   // [2:0] req_type
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [7:0]            m_tdata,   // [7:0] ascii_char
    output logic                  m_tlast    // last
);

    // Pipeline registers.
    itaf_stage_t       st_reg  [NSTAGE];
    itaf_stage_t       st_next [NSTAGE];
    logic [NSTAGE-1:0] vld_reg;
    logic [NSTAGE-1:0] vld_next;
    logic [NSTAGE:0]   rdy;

    // Emitter registers.
    logic             busy_reg, busy_next;
    logic [3:0]       pos_reg, pos_next;
    logic [3:0]       len_reg, len_next;
    logic [1:0]       npre_reg, npre_next;
    logic [3:0]       ndig_reg, ndig_next;
    logic [3:0]       dig_reg  [MAX_DIGITS];
    logic [3:0]       dig_next [MAX_DIGITS];
    logic [2:0]       kind_reg, kind_next;
    logic [7:0]       byte_reg, byte_next;

    logic             load_ok;
    logic             last_w;
    logic             neg_in;
    logic [VAL_W-1:0] mag_in;
    logic [3:0]       dig_idx;
    itaf_stage_t      tail;

    assign tail = st_reg[NSTAGE-1];

    // Signed decimal takes the magnitude of a negative operand.
    assign neg_in = (s_tuser == REQ_SDEC) && s_tdata[VAL_W-1];
    assign mag_in = neg_in ? (~s_tdata + {{(VAL_W-1){1'b0}}, 1'b1}) : s_tdata;

    // Stall chain: a stage advances when it is empty or the next one advances.
    always_comb begin
        rdy[NSTAGE] = load_ok;
        for (int k = NSTAGE - 1; k >= 0; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign s_tready = rdy[0];

    // Next values of the pipeline stages.
    always_comb begin
        vld_next[0]        = rdy[0] ? (s_tvalid && (s_tuser <= REQ_HEX)) : vld_reg[0];
        st_next[0]         = st_reg[0];
        if (rdy[0]) begin
            st_next[0].kind = s_tuser;
            st_next[0].neg  = neg_in;
            st_next[0].mag  = mag_in;
            st_next[0].sh   = mag_in;
            st_next[0].bcd  = '0;
        end
        for (int k = 1; k < NSTAGE; k++) begin
            vld_next[k] = rdy[k] ? vld_reg[k-1] : vld_reg[k];
            st_next[k]  = rdy[k] ? dabble4(st_reg[k-1]) : st_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < NSTAGE; k++) begin
            st_reg[k] <= st_next[k];
        end
    end

    // Output character selection from the emitter registers.
    assign last_w  = (pos_reg == len_reg - 4'd1);
    assign dig_idx = {2'b00, npre_reg} + ndig_reg - 4'd1 - pos_reg;

    always_comb begin
        if (kind_reg == REQ_CHAR) begin
            m_tdata = byte_reg;
        end else if (pos_reg < {2'b00, npre_reg}) begin
            if (pos_reg == 4'd0) begin
                m_tdata = (kind_reg == REQ_SDEC) ? CH_MINUS : CH_ZERO;
            end else begin
                m_tdata = CH_X;
            end
        end else if (last_w) begin
            m_tdata = CH_SPACE;
        end else if (dig_idx < 4'(MAX_DIGITS)) begin
            m_tdata = hex_char(dig_reg[dig_idx]);
        end else begin
            m_tdata = CH_ZERO;
        end
    end

    assign m_tvalid = busy_reg;
    assign m_tlast  = last_w;
    assign load_ok  = !busy_reg || (m_tready && last_w);

    // Emitter load: digit layout, significant digit count and run length.
    always_comb begin
        busy_next = busy_reg;
        pos_next  = pos_reg;
        len_next  = len_reg;
        npre_next = npre_reg;
        ndig_next = ndig_reg;
        kind_next = kind_reg;
        byte_next = byte_reg;
        for (int i = 0; i < MAX_DIGITS; i++) begin
            dig_next[i] = dig_reg[i];
        end

        if (load_ok) begin
            busy_next = vld_reg[NSTAGE-1];
            pos_next  = 4'd0;
            kind_next = tail.kind;
            byte_next = tail.mag[7:0];
            for (int i = 0; i < MAX_DIGITS; i++) begin
                dig_next[i] = 4'd0;
            end
            case (tail.kind)
                REQ_OCT: begin
                    for (int i = 0; i < MAX_DIGITS - 1; i++) begin
                        dig_next[i] = {1'b0, tail.mag[3*i +: 3]};
                    end
                    dig_next[MAX_DIGITS-1] = {2'b00, tail.mag[VAL_W-1 -: 2]};
                end
                REQ_HEX: begin
                    for (int i = 0; i < VAL_W / 4; i++) begin
                        dig_next[i] = tail.mag[4*i +: 4];
                    end
                end
                default: begin
                    for (int i = 0; i < DEC_DIGITS; i++) begin
                        dig_next[i] = tail.bcd[4*i +: 4];
                    end
                end
            endcase
            ndig_next = 4'd1;
            for (int i = 1; i < MAX_DIGITS; i++) begin
                if (dig_next[i] != 4'd0) begin
                    ndig_next = 4'(i + 1);
                end
            end
            case (tail.kind)
                REQ_SDEC: npre_next = tail.neg ? 2'd1 : 2'd0;
                REQ_OCT:  npre_next = 2'd1;
                REQ_HEX:  npre_next = 2'd2;
                default:  npre_next = 2'd0;
            endcase
            if (tail.kind == REQ_CHAR) begin
                len_next = 4'd1;
            end else begin
                len_next = {2'b00, npre_next} + ndig_next + 4'd1;
            end
        end else if (m_tready) begin
            pos_next = pos_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            pos_reg  <= 4'd0;
        end else begin
            busy_reg <= busy_next;
            pos_reg  <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        len_reg  <= len_next;
        npre_reg <= npre_next;
        ndig_reg <= ndig_next;
        kind_reg <= kind_next;
        byte_reg <= byte_next;
        for (int i = 0; i < MAX_DIGITS; i++) begin
            dig_reg[i] <= dig_next[i];
        end
    end

endmodule

`default_nettype wire

// File: tb/integer_to_ascii_formatter_top_tb.sv
// Self-checking testbench for the integer to ASCII formatter top level.
`timescale 1ns / 1ps

module integer_to_ascii_formatter_top_tb;
    import itaf_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 40;
    localparam int RANDOM_ITEMS  = 260;

    // One formatting request as it travels on the input channel.
    typedef struct {
        logic [2:0]       kind;
        logic [VAL_W-1:0] value;
    } fmt_request_t;

    // One expected character of a run.
    typedef struct {
        logic [7:0] ch;
        logic       last;
    } ascii_beat_t;

    logic             aclk     = 1'b0;
    logic             aresetn  = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [VAL_W-1:0] s_tdata  = '0;
    logic [2:0]       s_tuser  = REQ_CHAR;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [7:0]       m_tdata;
    logic             m_tlast;

    fmt_request_t request_queue[$];
    ascii_beat_t  ascii_expected[$];
    int           accepted_cnt   = 0;
    int           popped_cnt     = 0;
    int           total_requests = 0;
    int           mismatch_cnt   = 0;
    int           burst_left     = 0;
    int           gap_left       = 0;
    int           stall_mode     = 0;
    int           stall_left     = 0;
    int           pattern_phase  = 0;
    int           watchdog_cycles = 0;

    integer_to_ascii_formatter_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Free-running clock, 20 ns period.
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Build the character run for one request and queue it, flagging the final character.
    function automatic void predict_ascii_run(input logic [2:0] kind,
                                              input logic [VAL_W-1:0] value);
        string            digit_chars;
        logic [7:0]       run[$];
        logic [3:0]       digits[$];
        logic [VAL_W-1:0] mag;
        int               base;
        ascii_beat_t      beat;
        digit_chars = "0123456789ABCDEF";
        base = 0;
        mag  = value;
        case (kind)
            REQ_CHAR: run.push_back(value[7:0]);
            REQ_SDEC: begin
                base = 10;
                if (value[VAL_W-1]) begin
                    run.push_back(CH_MINUS);
                    mag = -value;
                end
            end
            REQ_UDEC: base = 10;
            REQ_OCT: begin
                base = 8;
                run.push_back(CH_ZERO);
            end
            REQ_HEX: begin
                base = 16;
                run.push_back(CH_ZERO);
                run.push_back(CH_X);
            end
            default: ;
        endcase
        // Numeric forms: digits most significant first, then a trailing space.
        if (base != 0) begin
            if (mag == '0) begin
                digits.push_front(4'd0);
            end
            while (mag != '0) begin
                digits.push_front(4'(mag % base));
                mag = mag / base;
            end
            foreach (digits[i]) begin
                run.push_back(digit_chars[digits[i]]);
            end
            run.push_back(CH_SPACE);
        end
        foreach (run[i]) begin
            beat.ch   = run[i];
            beat.last = (i == run.size() - 1);
            ascii_expected.push_back(beat);
        end
    endfunction

    // Operand classes: full random, small, narrowed, extremes and decimal digit boundaries.
    function automatic logic [VAL_W-1:0] pick_value();
        logic [VAL_W-1:0] v;
        logic [VAL_W-1:0] p10;
        int               k;
        case ($urandom_range(0, 5))
            0, 1: v = $urandom;
            2: v = $urandom_range(0, 20);
            3: v = $urandom >> $urandom_range(0, 31);
            4: begin
                case ($urandom_range(0, 4))
                    0: v = '0;
                    1: v = '1;
                    2: v = 32'h8000_0000;
                    3: v = 32'h7FFF_FFFF;
                    default: v = 32'h8000_0001;
                endcase
            end
            default: begin
                p10 = 1;
                k = $urandom_range(0, 9);
                repeat (k) p10 = p10 * 10;
                v = p10 + $urandom_range(0, 2) - 1;
                if ($urandom_range(0, 1)) begin
                    v = -v;
                end
            end
        endcase
        return v;
    endfunction

    // Queue one request for the driver.
    function automatic void add_request(input logic [2:0] kind, input logic [VAL_W-1:0] value);
        fmt_request_t r;
        r.kind  = kind;
        r.value = value;
        request_queue.push_back(r);
    endfunction

    // Sender: bursts of requests separated by random gaps; a pending request is held until taken.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && popped_cnt == accepted_cnt) begin
            // The presented request has not been taken yet, so keep it on the bus.
        end else begin
            if (popped_cnt != accepted_cnt) begin
                request_queue.pop_front();
                popped_cnt++;
            end
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (request_queue.size() > 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= request_queue[0].value;
                s_tuser  <= request_queue[0].kind;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    case ($urandom_range(0, 7))
                        0, 1, 2: gap_left = 0;
                        3: gap_left = $urandom_range(20, 40);
                        default: gap_left = $urandom_range(1, 8);
                    endcase
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: the stall behavior switches among several patterns every so often.
    always @(negedge aclk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 4);
            stall_left = $urandom_range(30, 200);
        end else begin
            stall_left--;
        end
        pattern_phase = (pattern_phase + 1) % 7;
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= $urandom_range(0, 1);
            2: m_tready <= ($urandom_range(0, 3) == 0);
            3: m_tready <= (pattern_phase < 4);
            default: m_tready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // Monitor: predict on each accepted request and check each accepted character.
    always @(posedge aclk) begin
        ascii_beat_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predict_ascii_run(s_tuser, s_tdata);
                accepted_cnt++;
            end
            if (m_tvalid && m_tready) begin
                if (ascii_expected.size() == 0) begin
                    mismatch_cnt++;
                    $display("%0t: unexpected character: expected none, actual 0x%02h last %0b",
                             $time, m_tdata, m_tlast);
                end else begin
                    want = ascii_expected.pop_front();
                    if (m_tdata !== want.ch) begin
                        mismatch_cnt++;
                        $display("%0t: ascii_char: expected 0x%02h, actual 0x%02h",
                                 $time, want.ch, m_tdata);
                    end
                    if (m_tlast !== want.last) begin
                        mismatch_cnt++;
                        $display("%0t: last: expected %0b, actual %0b",
                                 $time, want.last, m_tlast);
                    end
                end
            end
        end
    end

    // Watchdog: end the run if it takes far longer than the slowest correct run.
    initial begin
        while (watchdog_cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            watchdog_cycles++;
        end
        $display("integer_to_ascii_formatter_top: mismatch");
        $finish;
    end

    // Stimulus, reset and end of run.
    initial begin
        int valid_cnt;
        int r;
        logic [2:0] kind;

        // Directed requests: extremes of every format and the ignored selector codes.
        add_request(REQ_CHAR, 32'h0000_0000);
        add_request(REQ_CHAR, 32'hFFFF_FFFF);
        add_request(REQ_CHAR, 32'hABCD_EF41);
        add_request(REQ_SDEC, 32'h0000_0000);
        add_request(REQ_SDEC, 32'h0000_0001);
        add_request(REQ_SDEC, 32'hFFFF_FFFF);
        add_request(REQ_SDEC, 32'h8000_0000);
        add_request(REQ_SDEC, 32'h7FFF_FFFF);
        add_request(REQ_SDEC, 32'd123456789);
        add_request(REQ_UDEC, 32'h0000_0000);
        add_request(REQ_UDEC, 32'hFFFF_FFFF);
        add_request(REQ_UDEC, 32'd1000000000);
        add_request(REQ_UDEC, 32'd9);
        add_request(REQ_OCT,  32'h0000_0000);
        add_request(REQ_OCT,  32'hFFFF_FFFF);
        add_request(REQ_OCT,  32'd8);
        add_request(REQ_HEX,  32'h0000_0000);
        add_request(REQ_HEX,  32'hFFFF_FFFF);
        add_request(REQ_HEX,  32'hDEAD_BEEF);
        add_request(REQ_HEX,  32'h0000_000A);
        add_request(3'd5,     32'h1234_5678);
        add_request(3'd6,     32'hFFFF_FFFF);
        add_request(3'd7,     32'h0000_0000);

        // Random requests, mostly valid formats with a sprinkle of unused selectors.
        valid_cnt = 0;
        while (valid_cnt < RANDOM_ITEMS) begin
            r = $urandom_range(0, 19);
            if (r < 18) begin
                kind = 3'(r % 5);
                valid_cnt++;
            end else begin
                kind = 3'($urandom_range(5, 7));
            end
            add_request(kind, pick_value());
        end
        total_requests = request_queue.size();

        // Hold reset, then release it away from the sampling edge.
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Wait for every request to be taken and every character to arrive, then drain.
        while (accepted_cnt < total_requests) @(posedge aclk);
        while (ascii_expected.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (ascii_expected.size() != 0) begin
            mismatch_cnt++;
            $display("%0t: characters still expected: %0d, actual 0", $time,
                     ascii_expected.size());
        end
        if (mismatch_cnt == 0) begin
            $display("integer_to_ascii_formatter_top: match");
        end else begin
            $display("integer_to_ascii_formatter_top: mismatch");
        end
        $finish;
    end

endmodule
